@@ src/nr_pkg.sv @@
// ----------------------------------------------------------------------------
// nr_pkg
// Shared codes and controller/datapath interface types for the router.
// ----------------------------------------------------------------------------
package nr_pkg;

  localparam logic [2:0] REQ_ENABLE      = 3'd0;
  localparam logic [2:0] REQ_SUBSCRIBE   = 3'd1;
  localparam logic [2:0] REQ_UNSUBSCRIBE = 3'd2;
  localparam logic [2:0] REQ_RECEIVE     = 3'd3;
  localparam logic [2:0] REQ_PUB_SUBS    = 3'd4;
  localparam logic [2:0] REQ_PUB_ONE     = 3'd5;
  localparam logic [2:0] REQ_PUB_ALL     = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_SUBFULL  = 3'd3;
  localparam logic [2:0] ST_RINGFULL = 3'd4;

  localparam logic [4:0] COUNT_CAP = 5'd16;

  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       sub_last;
    logic       sub_wr_new;
    logic       sub_wr_move;
    logic       ring_push;
    logic       ring_pop;
    logic       en_set;
    logic       match;
    logic       woke;
    logic       k_inc;
    logic       finish;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       c_valid;
    logic       cli_en;
    logic       sub_more;
    logic       sub_hit;
    logic       sub_room;
    logic       ring_more;
    logic       ring_hit;
    logic       ring_room;
    logic       ring_empty;
    logic       k_ok;
    logic       k_last;
    logic       flag_skip;
    logic       flag_full_ok;
    logic       out_free;
  } sts_t;

endpackage

@@ src/notification_router.sv @@
// ----------------------------------------------------------------------------
// notification_router
// Event notification router: per-client enable, subscription table and
// pending ring, with subscribe, unsubscribe, receive and publish requests.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_stall   req_type, client, note_id, publish_flags
//  output    out_valid / out_stall status, note_out, matched_mask,
//                                  match_count, wake_mask
//
//  one request at a time; the sequencer reads one memory entry at a time, in a read state and a compare state.
//  synchronous reset clears enables, counts and ring pointers at once.
//  a finished result sits in the output register; a stalled output holds the
//  sequencer only at the point where the next result would be written.
// ----------------------------------------------------------------------------
module notification_router
  import nr_pkg::*;
#(
  parameter int CLIENTS    = 16,
  parameter int SUB_SLOTS  = 17,
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [3:0]  client,
  input  logic [31:0] note_id,
  input  logic [1:0]  publish_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] note_out,
  output logic [15:0] matched_mask,
  output logic [4:0]  match_count,
  output logic [15:0] wake_mask
);

  cmd_t cmd;
  sts_t sts;

  nr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  nr_datapath #(
    .CLIENTS    (CLIENTS),
    .SUB_SLOTS  (SUB_SLOTS),
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .client        (client),
    .note_id       (note_id),
    .publish_flags (publish_flags),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .note_out      (note_out),
    .matched_mask  (matched_mask),
    .match_count   (match_count),
    .wake_mask     (wake_mask)
  );

endmodule

@@ src/nr_ram.sv @@
// ----------------------------------------------------------------------------
// nr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/nr_ctrl.sv @@
// ----------------------------------------------------------------------------
// nr_ctrl
// Request sequencer: walks table scans, ring scans and the publish client loop.
// ----------------------------------------------------------------------------
module nr_ctrl
  import nr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SUB_RD, S_SUB_CMP, S_UNS_RD, S_UNS_WR, S_RECV_RD, S_RECV,
    S_PUB_CHK, S_DELIVER, S_RING_RD, S_RING_CMP, S_PUSH, S_PUB_NEXT, S_DONE
  } state_t;

  state_t     state, state_next;
  logic [2:0] st_code, st_code_next;
  logic       is_subs;

  assign in_stall = (state != S_IDLE);
  assign is_subs  = (sts.req == REQ_PUB_SUBS);

  always_comb begin
    cmd          = '0;
    cmd.st       = st_code;
    state_next   = state;
    st_code_next = st_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next   = S_DONE;
        st_code_next = ST_NOTFOUND;
        case (sts.req)
          REQ_ENABLE: begin
            if (sts.c_valid) begin
              cmd.en_set   = 1'b1;
              st_code_next = ST_OK;
            end
          end
          REQ_SUBSCRIBE, REQ_UNSUBSCRIBE: begin
            if (sts.cli_en) state_next = S_SUB_RD;
          end
          REQ_RECEIVE: begin
            if (sts.cli_en && !sts.ring_empty) state_next = S_RECV_RD;
          end
          REQ_PUB_SUBS, REQ_PUB_ALL: begin
            state_next = S_PUB_CHK;
          end
          REQ_PUB_ONE: begin
            if (sts.cli_en) state_next = S_PUB_CHK;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_SUB_RD: begin
        if (sts.sub_more) begin
          state_next = S_SUB_CMP;
        end else begin
          case (sts.req)
            REQ_SUBSCRIBE: begin
              state_next = S_DONE;
              if (sts.sub_room) begin
                cmd.sub_wr_new = 1'b1;
                st_code_next   = ST_OK;
              end else begin
                st_code_next = ST_SUBFULL;
              end
            end
            REQ_UNSUBSCRIBE: begin
              state_next   = S_DONE;
              st_code_next = ST_NOTFOUND;
            end
            default: begin
              state_next = S_PUB_NEXT;
            end
          endcase
        end
      end
      S_SUB_CMP: begin
        if (sts.sub_hit) begin
          case (sts.req)
            REQ_SUBSCRIBE: begin
              state_next   = S_DONE;
              st_code_next = ST_DUP;
            end
            REQ_UNSUBSCRIBE: begin
              state_next = S_UNS_RD;
            end
            default: begin
              state_next = S_DELIVER;
            end
          endcase
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SUB_RD;
        end
      end
      S_UNS_RD: begin
        // fetch the last entry so it can fill the hole
        cmd.sub_last = 1'b1;
        state_next   = S_UNS_WR;
      end
      S_UNS_WR: begin
        cmd.sub_wr_move = 1'b1;
        st_code_next    = ST_OK;
        state_next      = S_DONE;
      end
      S_RECV_RD: begin
        state_next = S_RECV;
      end
      S_RECV: begin
        cmd.ring_pop = 1'b1;
        st_code_next = ST_OK;
        state_next   = S_DONE;
      end
      S_PUB_CHK: begin
        cmd.idx_clr = 1'b1;
        if (!sts.k_ok) begin
          state_next = S_PUB_NEXT;
        end else if (is_subs) begin
          state_next = S_SUB_RD;
        end else begin
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        cmd.idx_clr = 1'b1;
        if (is_subs && sts.flag_skip) begin
          state_next = S_RING_RD;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_RING_RD: begin
        state_next = sts.ring_more ? S_RING_CMP : S_PUSH;
      end
      S_RING_CMP: begin
        if (sts.ring_hit) begin
          // already pending: success without a new entry
          cmd.match  = 1'b1;
          state_next = S_PUB_NEXT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RING_RD;
        end
      end
      S_PUSH: begin
        if (sts.ring_room) begin
          cmd.ring_push = 1'b1;
          cmd.match     = 1'b1;
          cmd.woke      = 1'b1;
          state_next    = S_PUB_NEXT;
        end else if (is_subs && sts.flag_full_ok) begin
          cmd.match  = 1'b1;
          state_next = S_PUB_NEXT;
        end else begin
          st_code_next = ST_RINGFULL;
          state_next   = S_DONE;
        end
      end
      S_PUB_NEXT: begin
        if (sts.k_last) begin
          st_code_next = ST_OK;
          state_next   = S_DONE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_PUB_CHK;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      st_code <= ST_OK;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

endmodule

@@ src/nr_datapath.sv @@
// ----------------------------------------------------------------------------
// nr_datapath
// Per-client tables, subscription and ring memories, publish accumulators and
// the result register.
// ----------------------------------------------------------------------------
module nr_datapath
  import nr_pkg::*;
#(
  parameter int CLIENTS    = 16,
  parameter int SUB_SLOTS  = 17,
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  req_type,
  input  logic [3:0]  client,
  input  logic [31:0] note_id,
  input  logic [1:0]  publish_flags,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [31:0] note_out,
  output logic [15:0] matched_mask,
  output logic [4:0]  match_count,
  output logic [15:0] wake_mask
);

  localparam int CW     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SCW    = $clog2(SUB_SLOTS + 1);
  localparam int RW     = $clog2(RING_DEPTH);
  localparam int RCW    = $clog2(RING_DEPTH + 1);
  localparam int IW     = (SCW > RCW) ? SCW : RCW;
  localparam int PW     = RCW + 1;
  localparam int SDEPTH = CLIENTS * SUB_SLOTS;
  localparam int RDEPTH = CLIENTS * RING_DEPTH;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int RAW    = $clog2(RDEPTH);

  logic [2:0]   req_r;
  logic [3:0]   cli_r;
  logic [31:0]  id_r;
  logic [1:0]   flags_r;
  logic [CW-1:0] k;
  logic [IW-1:0] idx;

  logic           enabled  [CLIENTS];
  logic [SCW-1:0] sub_cnt  [CLIENTS];
  logic [RW-1:0]  ring_head[CLIENTS];
  logic [RW-1:0]  ring_tail[CLIENTS];
  logic [RCW-1:0] ring_cnt [CLIENTS];

  logic [31:0] note_r;
  logic [15:0] matched_r, woke_r;
  logic [4:0]  mcount_r;

  logic           is_pub;
  logic [CW-1:0]  c_sel, sel;
  logic [5:0]     k6;
  logic [SCW-1:0] cur_scnt;
  logic [RW-1:0]  cur_head, cur_tail;
  logic [RCW-1:0] cur_rcnt;
  logic [PW-1:0]  psum, rpos;
  logic [SAW-1:0] sub_base, sub_raddr, sub_waddr;
  logic [RAW-1:0] ring_base, ring_raddr, ring_waddr;
  logic [31:0]    sub_rdata, ring_rdata, sub_wdata;
  logic           sub_we;

  function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] v);
    return (v == RW'(RING_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign is_pub   = (req_r == REQ_PUB_SUBS) || (req_r == REQ_PUB_ONE) ||
                    (req_r == REQ_PUB_ALL);
  assign c_sel    = CW'(cli_r);
  assign sel      = is_pub ? k : c_sel;
  assign k6       = 6'(k);
  assign cur_scnt = sub_cnt[sel];
  assign cur_head = ring_head[sel];
  assign cur_tail = ring_tail[sel];
  assign cur_rcnt = ring_cnt[sel];

  // ring scan position wraps at most once
  assign psum = PW'(cur_head) + PW'(idx);
  assign rpos = (psum >= PW'(RING_DEPTH)) ? psum - PW'(RING_DEPTH) : psum;

  assign sub_base   = SAW'(sel) * SAW'(SUB_SLOTS);
  assign sub_raddr  = sub_base + (cmd.sub_last ? SAW'(cur_scnt - 1'b1) : SAW'(idx));
  assign sub_waddr  = sub_base + (cmd.sub_wr_new ? SAW'(cur_scnt) : SAW'(idx));
  assign sub_wdata  = cmd.sub_wr_new ? id_r : sub_rdata;
  assign sub_we     = cmd.sub_wr_new | cmd.sub_wr_move;
  assign ring_base  = RAW'(sel) * RAW'(RING_DEPTH);
  assign ring_raddr = ring_base + RAW'(rpos);
  assign ring_waddr = ring_base + RAW'(cur_tail);

  nr_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_sub_ram (
    .clk     (clk),
    .wr_en   (sub_we),
    .wr_addr (sub_waddr),
    .wr_data (sub_wdata),
    .rd_addr (sub_raddr),
    .rd_data (sub_rdata)
  );

  nr_ram #(.WIDTH(32), .DEPTH(RDEPTH)) u_ring_ram (
    .clk     (clk),
    .wr_en   (cmd.ring_push),
    .wr_addr (ring_waddr),
    .wr_data (id_r),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  always_comb begin
    sts.req          = req_r;
    sts.c_valid      = (7'(cli_r) < 7'(CLIENTS));
    sts.cli_en       = sts.c_valid && enabled[c_sel];
    sts.sub_more     = (idx < IW'(cur_scnt));
    sts.sub_hit      = (sub_rdata == id_r);
    sts.sub_room     = (cur_scnt < SCW'(SUB_SLOTS));
    sts.ring_more    = (idx < IW'(cur_rcnt));
    sts.ring_hit     = (ring_rdata == id_r);
    sts.ring_room    = (cur_rcnt < RCW'(RING_DEPTH));
    sts.ring_empty   = (cur_rcnt == '0);
    sts.k_ok         = enabled[k] && ((req_r != REQ_PUB_ONE) || (k6 == 6'(cli_r)));
    sts.k_last       = (k == CW'(CLIENTS - 1));
    sts.flag_skip    = flags_r[0];
    sts.flag_full_ok = flags_r[1];
    sts.out_free     = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) begin
        enabled[i]   <= 1'b0;
        sub_cnt[i]   <= '0;
        ring_head[i] <= '0;
        ring_tail[i] <= '0;
        ring_cnt[i]  <= '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.en_set) begin
        enabled[sel] <= 1'b1;
      end
      if (cmd.sub_wr_new) begin
        sub_cnt[sel] <= cur_scnt + 1'b1;
      end else if (cmd.sub_wr_move) begin
        sub_cnt[sel] <= cur_scnt - 1'b1;
      end
      if (cmd.ring_push) begin
        ring_tail[sel] <= wrap_inc(cur_tail);
        ring_cnt[sel]  <= cur_rcnt + 1'b1;
      end else if (cmd.ring_pop) begin
        ring_head[sel] <= wrap_inc(cur_head);
        ring_cnt[sel]  <= cur_rcnt - 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= req_type;
      cli_r     <= client;
      id_r      <= note_id;
      flags_r   <= publish_flags;
      k         <= '0;
      idx       <= '0;
      note_r    <= '0;
      matched_r <= '0;
      woke_r    <= '0;
      mcount_r  <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.ring_pop) begin
        note_r <= ring_rdata;
      end
      if (cmd.match) begin
        if (mcount_r != COUNT_CAP) begin
          mcount_r <= mcount_r + 1'b1;
        end
        // only the low sixteen slots show in the masks
        if (k6 < 6'd16) begin
          matched_r[k6[3:0]] <= 1'b1;
          if (cmd.woke) begin
            woke_r[k6[3:0]] <= 1'b1;
          end
        end
      end
    end
    if (cmd.finish) begin
      status       <= cmd.st;
      note_out     <= note_r;
      matched_mask <= matched_r;
      match_count  <= mcount_r;
      wake_mask    <= woke_r;
    end
  end

endmodule

@@ sim/notification_router_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// notification_router_tb
// Drives enable, subscribe, unsubscribe, receive, publish and unknown requests into
// the router, predicts each result from a local copy of the client tables and
// compares every result field against the prediction, under random idling and output stalls.
// ----------------------------------------------------------------------------
module notification_router_tb;
  import nr_pkg::*;

  localparam int NCLI = 16;
  localparam int NSUB = 17;
  localparam int NRING = 16;
  localparam int IDLE_LIMIT = 20000;

  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam int PUSH_DONE = 0;
  localparam int PUSH_WOKE = 1;
  localparam int PUSH_FAIL = 2;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] note;
    logic [15:0] matched;
    logic [4:0]  cnt;
    logic [15:0] woke;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [3:0]  client = '0;
  logic [31:0] note_id = '0;
  logic [1:0]  publish_flags = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] note_out;
  logic [15:0] matched_mask;
  logic [4:0]  match_count;
  logic [15:0] wake_mask;

  notification_router dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the router state
  bit          en_q [NCLI];
  logic [31:0] subs_q [NCLI][NSUB];
  int          nsubs_q [NCLI];
  logic [31:0] ring_q [NCLI][NRING];
  int          head_q [NCLI];
  int          tail_q [NCLI];
  int          fill_q [NCLI];

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      stall_mode = 0;
  int      burst_left = 0;
  logic [31:0] id_pool [8];

  function automatic bit subscribed(int c, logic [31:0] id);
    for (int i = 0; i < nsubs_q[c]; i++)
      if (subs_q[c][i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int push_note(int c, logic [31:0] id, logic [1:0] fl);
    int p;
    p = head_q[c];
    if (fl[0]) begin
      for (int i = 0; i < fill_q[c]; i++) begin
        if (ring_q[c][p] == id) return PUSH_DONE;
        p = (p + 1) % NRING;
      end
    end
    if (fill_q[c] < NRING) begin
      ring_q[c][tail_q[c]] = id;
      tail_q[c] = (tail_q[c] + 1) % NRING;
      fill_q[c]++;
      return PUSH_WOKE;
    end
    return fl[1] ? PUSH_DONE : PUSH_FAIL;
  endfunction

  function automatic answer_t route_request(logic [2:0] rq, int c, logic [31:0] id,
                                            logic [1:0] fl);
    answer_t a;
    bit en;
    int r;
    a = '0;
    en = en_q[c];
    case (rq)
      REQ_ENABLE: en_q[c] = 1'b1;
      REQ_SUBSCRIBE: begin
        if (!en) a.st = ST_NOTFOUND;
        else if (subscribed(c, id)) a.st = ST_DUP;
        else if (nsubs_q[c] < NSUB) begin
          subs_q[c][nsubs_q[c]] = id;
          nsubs_q[c]++;
        end else a.st = ST_SUBFULL;
      end
      REQ_UNSUBSCRIBE: begin
        a.st = ST_NOTFOUND;
        if (en) begin
          for (int i = 0; i < nsubs_q[c]; i++) begin
            if (subs_q[c][i] == id) begin
              nsubs_q[c]--;
              subs_q[c][i] = subs_q[c][nsubs_q[c]];
              a.st = ST_OK;
              break;
            end
          end
        end
      end
      REQ_RECEIVE: begin
        if (!en || fill_q[c] == 0) a.st = ST_NOTFOUND;
        else begin
          fill_q[c]--;
          a.note = ring_q[c][head_q[c]];
          head_q[c] = (head_q[c] + 1) % NRING;
        end
      end
      REQ_PUB_SUBS, REQ_PUB_ONE, REQ_PUB_ALL: begin
        if (rq == REQ_PUB_ONE && !en) a.st = ST_NOTFOUND;
        else begin
          for (int k = 0; k < NCLI; k++) begin
            if (rq == REQ_PUB_ONE && k != c) continue;
            if (!en_q[k]) continue;
            if (rq == REQ_PUB_SUBS && !subscribed(k, id)) continue;
            r = push_note(k, id, rq == REQ_PUB_SUBS ? fl : 2'b00);
            if (r == PUSH_FAIL) begin
              a.st = ST_RINGFULL;
              break;
            end
            if (a.cnt < COUNT_CAP) a.cnt++;
            a.matched[k] = 1'b1;
            if (r == PUSH_WOKE) a.woke[k] = 1'b1;
          end
        end
      end
      default: a.st = ST_NOTFOUND;
    endcase
    return a;
  endfunction

  // valid stays up between requests of one burst
  task automatic send_request(logic [2:0] rq, logic [3:0] c, logic [31:0] id,
                              logic [1:0] fl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= rq;
    client <= c;
    note_id <= id;
    publish_flags <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(route_request(rq, c, id, fl));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // receiver stall pattern, changes mode now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request pending");
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st || note_out !== want.note ||
            matched_mask !== want.matched || match_count !== want.cnt ||
            wake_mask !== want.woke) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d note %h m %h n %0d w %h, got %0d %h %h %0d %h",
                     want.st, want.note, want.matched, want.cnt, want.woke,
                     status, note_out, matched_mask, match_count, wake_mask);
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else if (in_valid || pending_answers.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("notification_router_tb: errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return id_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  task automatic test_directed();
    send_request(REQ_RECEIVE, 4'd0, 32'h0, 2'b00);          // disabled slot
    send_request(REQ_SUBSCRIBE, 4'd3, 32'h1, 2'b00);
    send_request(REQ_PUB_ONE, 4'd3, 32'h1, 2'b00);
    send_request(REQ_UNUSED, 4'd5, 32'h5, 2'b11);            // unknown request
    send_request(REQ_ENABLE, 4'd0, 32'h0, 2'b00);
    send_request(REQ_ENABLE, 4'd15, 32'h0, 2'b00);
    send_request(REQ_SUBSCRIBE, 4'd0, 32'hFFFF_FFFF, 2'b00);
    send_request(REQ_SUBSCRIBE, 4'd0, 32'hFFFF_FFFF, 2'b00); // duplicate
    send_request(REQ_SUBSCRIBE, 4'd15, 32'hFFFF_FFFF, 2'b00);
    send_request(REQ_SUBSCRIBE, 4'd15, 32'h0, 2'b00);
    send_request(REQ_PUB_SUBS, 4'd0, 32'hFFFF_FFFF, 2'b01);
    send_request(REQ_PUB_SUBS, 4'd0, 32'hFFFF_FFFF, 2'b01);  // skip pending
    send_request(REQ_PUB_ALL, 4'd0, 32'hA5A5_5A5A, 2'b00);
    send_request(REQ_RECEIVE, 4'd0, 32'h0, 2'b00);
    send_request(REQ_RECEIVE, 4'd15, 32'h0, 2'b00);
    send_request(REQ_UNSUBSCRIBE, 4'd15, 32'hFFFF_FFFF, 2'b00);
    send_request(REQ_UNSUBSCRIBE, 4'd15, 32'h1234, 2'b00);
    send_request(REQ_PUB_ONE, 4'd15, 32'h0, 2'b10);
    send_request(REQ_RECEIVE, 4'd15, 32'h0, 2'b00);
    send_request(REQ_RECEIVE, 4'd15, 32'h0, 2'b00);
    send_request(REQ_RECEIVE, 4'd15, 32'h0, 2'b00);          // empty ring
  endtask

  // fill a table to its limit and a ring until it overflows
  task automatic test_limits();
    for (int i = 0; i <= NSUB; i++) send_request(REQ_SUBSCRIBE, 4'd0, 32'h100 + i, 2'b00);
    send_request(REQ_UNSUBSCRIBE, 4'd0, 32'h101, 2'b00);
    send_request(REQ_SUBSCRIBE, 4'd0, 32'h7, 2'b00);
    for (int i = 0; i < NRING + 2; i++) send_request(REQ_PUB_ALL, 4'd0, 32'h200 + i, 2'b00);
    send_request(REQ_PUB_SUBS, 4'd0, 32'h7, 2'b00);          // ring full
    send_request(REQ_PUB_SUBS, 4'd0, 32'h7, 2'b10);          // full counts ok
    drain();
    for (int i = 0; i < NRING + 1; i++) send_request(REQ_RECEIVE, 4'd0, 32'h0, 2'b00);
  endtask

  task automatic test_random();
    logic [2:0] rq;
    int w;
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
    for (int n = 0; n < 1700; n++) begin
      if (n == 850) drain();
      w = $urandom_range(0, 99);
      if (w < 5) rq = REQ_ENABLE;
      else if (w < 22) rq = REQ_SUBSCRIBE;
      else if (w < 32) rq = REQ_UNSUBSCRIBE;
      else if (w < 60) rq = REQ_RECEIVE;
      else if (w < 80) rq = REQ_PUB_SUBS;
      else if (w < 88) rq = REQ_PUB_ONE;
      else if (w < 97) rq = REQ_PUB_ALL;
      else rq = REQ_UNUSED;
      send_request(rq, 4'($urandom_range(0, 15)), pick_id(), 2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    test_random();
    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0) $display("notification_router_tb: clean");
    else $display("notification_router_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/nr_pkg.sv
src/nr_ram.sv
src/nr_ctrl.sv
src/nr_datapath.sv
src/notification_router.sv
sim/notification_router_tb.sv
